@@ hw/rtl/peak_audio_normalizer_macros.svh @@
// assertion helpers for the peak normaliser, clocked on clk and held off during reset
`ifndef PEAK_AUDIO_NORMALIZER_MACROS_SVH
`define PEAK_AUDIO_NORMALIZER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PAN_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("peak normaliser check failed");

// next-cycle implication
`define PAN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("peak normaliser check failed");

`else

`define PAN_ASSERT_IMPL(label, ante, cons)
`define PAN_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hw/rtl/pan_pkg.sv @@
package pan_pkg;

    // sample and register widths
    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 15;
    localparam int PEAK_W      = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // default gain fraction and reset values
    localparam int GAIN_FRAC_BITS_DEF = 16;
    localparam int TARGET_RESET       = 29491;
    localparam int FLOOR_RESET        = 256;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_LEVEL = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_QUIET_FLOOR  = CFG_INDEX_W'(1);

    // pass codes
    localparam logic MODE_MEASURE = 1'b0;
    localparam logic MODE_APPLY   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DONE,
        ST_MUL,
        ST_SAT
    } pan_state_t;

    typedef struct packed {
        logic capture;
        logic measure;
        logic set_unity;
        logic div_load;
        logic div_step;
        logic gain_write;
        logic mul;
        logic emit;
    } pan_cmd_t;

    typedef struct packed {
        logic gain_unity;
        logic div_done;
    } pan_status_t;

endpackage

@@ hw/rtl/pan_ctrl.sv @@
module pan_ctrl
    import pan_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        mode,
    input  logic        last,
    input  pan_status_t status,
    output pan_cmd_t    cmd,
    output logic        busy
);

    pan_state_t state_reg;
    pan_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (mode == MODE_APPLY)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        cmd.measure = 1'b1;
                        if (last)
                        begin
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                if (status.gain_unity)
                begin
                    cmd.set_unity = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                cmd.gain_write = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ hw/rtl/pan_dp.sv @@
module pan_dp
    import pan_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  pan_cmd_t                   cmd,
    output pan_status_t                status,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last,
    input  logic                       cfg_valid,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output logic signed [SAMPLE_W-1:0] scaled_sample,
    output logic                       last_out,
    output logic                       result_valid
);

    localparam int GAIN_W   = GAIN_FRAC_BITS + 7;
    localparam int DIV_W    = LEVEL_W + GAIN_FRAC_BITS;
    localparam int CNT_W    = $clog2(DIV_W + 1);
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    localparam int SHIFT_W  = PROD_W - GAIN_FRAC_BITS;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1) << GAIN_FRAC_BITS;

    logic [LEVEL_W-1:0]         target_reg;
    logic [LEVEL_W-1:0]         floor_reg;
    logic [PEAK_W-1:0]          peak_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;
    logic [DIV_W-1:0]           quot_reg;
    logic [PEAK_W-1:0]          rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] out_reg;
    logic                       last_out_reg;
    logic                       valid_reg;

    logic [SAMPLE_W:0]          sample_ext;
    logic [PEAK_W-1:0]          mag;
    logic [PEAK_W:0]            shifted;
    logic [PEAK_W+1:0]          diff;
    logic [GAIN_W-1:0]          gain_sat;
    logic signed [SHIFT_W-1:0]  scaled;
    logic                       in_range;
    logic signed [SAMPLE_W-1:0] sat_value;

    // magnitude of the incoming sample, the most negative value gives 32768
    assign sample_ext = {sample[SAMPLE_W-1], sample};
    assign mag = sample[SAMPLE_W-1] ? PEAK_W'(-sample_ext) : PEAK_W'(sample_ext);

    // unity gain when peak is zero, below the floor or at or above the target
    assign status.gain_unity = (peak_reg == '0)
                            || (peak_reg < {1'b0, floor_reg})
                            || (peak_reg >= {1'b0, target_reg});
    assign status.div_done   = (cnt_reg == '0);

    // one restoring division step
    assign shifted = {rem_reg, quot_reg[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, peak_reg};

    // clamp the quotient to the gain register
    assign gain_sat = (|quot_reg[DIV_W-1:GAIN_W]) ? '1 : quot_reg[GAIN_W-1:0];

    // floor shift and saturation
    assign scaled   = SHIFT_W'(prod_reg >>> GAIN_FRAC_BITS);
    assign in_range = (&scaled[SHIFT_W-1:SAMPLE_W-1]) || !(|scaled[SHIFT_W-1:SAMPLE_W-1]);
    assign sat_value = in_range ? scaled[SAMPLE_W-1:0]
                     : {scaled[SHIFT_W-1], {(SAMPLE_W-1){!scaled[SHIFT_W-1]}}};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= LEVEL_W'(TARGET_RESET);
            floor_reg  <= LEVEL_W'(FLOOR_RESET);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_TARGET_LEVEL)
            begin
                target_reg <= cfg_data[LEVEL_W-1:0];
            end
            else if (cfg_index == REG_QUIET_FLOOR)
            begin
                floor_reg <= cfg_data[LEVEL_W-1:0];
            end
        end
    end

    // peak and gain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
            gain_reg <= GAIN_UNITY;
        end
        else
        begin
            if (cmd.measure && (mag > peak_reg))
            begin
                peak_reg <= mag;
            end
            if (cmd.set_unity)
            begin
                gain_reg <= GAIN_UNITY;
            end
            if (cmd.gain_write)
            begin
                gain_reg <= gain_sat;
            end
            if (cmd.emit && last_reg)
            begin
                peak_reg <= '0;
                gain_reg <= GAIN_UNITY;
            end
        end
    end

    // divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            cnt_reg <= CNT_W'(DIV_W);
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // divider quotient and remainder
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quot_reg <= {target_reg, {GAIN_FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!diff[PEAK_W+1])
            begin
                rem_reg  <= diff[PEAK_W-1:0];
                quot_reg <= {quot_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[PEAK_W-1:0];
                quot_reg <= {quot_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    // sample capture, product and result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
            last_reg   <= last;
        end
        if (cmd.mul)
        begin
            prod_reg <= sample_reg * $signed({1'b0, gain_reg});
        end
        if (cmd.emit)
        begin
            out_reg      <= sat_value;
            last_out_reg <= last_reg;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
        end
    end

    assign scaled_sample = out_reg;
    assign last_out      = last_out_reg;
    assign result_valid  = valid_reg;

endmodule

@@ hw/rtl/peak_audio_normalizer.sv @@
// Peak normaliser for signed 16-bit PCM. A measure beat (mode 0) gives no result; the
// measure beat marked last also runs a restoring divider, one quotient bit per cycle,
// unless the gain comes out unity, and busy stays high until the new gain is set. An
// apply beat (mode 1) runs through one multiply stage and one shift-and-saturate stage
// while busy is high, and result_valid then pulses for exactly one cycle. The receiver
// cannot stall, so it must take every strobed result.
// The configuration port is always ready; write it only while the block is idle.
`include "peak_audio_normalizer_macros.svh"

module peak_audio_normalizer
    import pan_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       mode,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output logic                       result_valid,
    output logic signed [SAMPLE_W-1:0] scaled_sample,
    output logic                       last_out
);

    pan_cmd_t    cmd;
    pan_status_t status;

    assign cfg_ready = 1'b1;

    // controller
    pan_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .last   (last),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // datapath
    pan_dp #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample        (sample),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .scaled_sample (scaled_sample),
        .last_out      (last_out),
        .result_valid  (result_valid)
    );

    // an apply beat gives its result after the multiply and shift-and-saturate steps
    `PAN_ASSERT_IMPL(a_apply_result, start && !busy && (mode == MODE_APPLY), ##3 result_valid)
    // a plain measure beat leaves the block ready in the next cycle
    `PAN_ASSERT_NEXT(a_measure_free, start && !busy && (mode == MODE_MEASURE) && !last, !busy)
    // results never come in consecutive cycles
    `PAN_ASSERT_NEXT(a_single_strobe, result_valid, !result_valid)
    // a result only follows the shift-and-saturate step
    `PAN_ASSERT_IMPL(a_strobe_source, result_valid, $past(cmd.emit))

endmodule
